// ===== sv/assert_macros.svh =====
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/itp_pkg.sv =====
// Types, constants and helpers shared by the infix-to-postfix converter.
`default_nettype none
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int QDEPTH      = 2;
  localparam int QA_W        = $clog2(QDEPTH);
  localparam int QC_W        = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [1:0] PREC_NONE = 2'd0;
  localparam logic [1:0] PREC_ADD  = 2'd1;
  localparam logic [1:0] PREC_MUL  = 2'd2;
  localparam logic [1:0] PREC_POW  = 2'd3;

  typedef enum logic [2:0] {
    CLS_SKIP,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER,
    CLS_OPND
  } cls_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNMATCHED = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPEN,
    ST_OPND,
    ST_OPER,
    ST_CLOSE,
    ST_FLUSH,
    ST_DONE
  } state_e;

  typedef struct packed {
    cls_e       cls;
    logic [7:0] ch;
    logic [1:0] prec;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       eoe;
    err_e       err;
  } result_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    case (c)
      CH_CARET:           p = PREC_POW;
      CH_STAR, CH_SLASH:  p = PREC_MUL;
      CH_PLUS, CH_MINUS:  p = PREC_ADD;
      default:            p = PREC_NONE;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== sv/itp_front.sv =====
// Front end: takes input characters and classifies them into commands.
`default_nettype none
module itp_front (
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  input  wire logic [7:0]    s_tdata_i,
  input  wire logic          s_tlast_i,
  input  wire logic          q_full_i,
  output logic               q_wr_o,
  output itp_pkg::cmd_t      q_cmd_o
);
  import itp_pkg::*;

  logic [1:0] prec;

  assign prec       = prec_of(s_tdata_i);
  assign s_tready_o = !q_full_i;
  assign q_wr_o     = s_tvalid_i && !q_full_i;

  always_comb begin
    q_cmd_o.ch   = s_tdata_i;
    q_cmd_o.prec = prec;
    q_cmd_o.last = s_tlast_i;
    if (s_tdata_i == CH_SPACE || s_tdata_i == CH_TAB) begin
      q_cmd_o.cls = CLS_SKIP;
    end else if (s_tdata_i == CH_LPAREN) begin
      q_cmd_o.cls = CLS_OPEN;
    end else if (s_tdata_i == CH_RPAREN) begin
      q_cmd_o.cls = CLS_CLOSE;
    end else if (prec != PREC_NONE) begin
      q_cmd_o.cls = CLS_OPER;
    end else begin
      q_cmd_o.cls = CLS_OPND;
    end
  end

endmodule
`default_nettype wire

// ===== sv/itp_queue.sv =====
// Short command queue between the front end and the stack engine.
`default_nettype none
`include "assert_macros.svh"
module itp_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  wire itp_pkg::cmd_t wr_cmd_i,
  output logic               full_o,
  input  wire logic          rd_i,
  output logic               valid_o,
  output itp_pkg::cmd_t      rd_cmd_o
);
  import itp_pkg::*;

  cmd_t             entry_q [QDEPTH];
  logic [QA_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QA_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o   = cnt_q == QC_W'(QDEPTH);
  assign valid_o  = cnt_q != '0;
  assign rd_cmd_o = entry_q[rd_ptr_q];
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QA_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QA_W'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QA_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QA_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + QC_W'(1);
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  `ASSERT_ALWAYS(a_q_cnt_bound, cnt_q <= QC_W'(QDEPTH), "queue count past depth")

endmodule
`default_nettype wire

// ===== sv/itp_engine.sv =====
// Back end: operator stack, shunting-yard sequencer and result registers.
`default_nettype none
`include "assert_macros.svh"
module itp_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire itp_pkg::cmd_t cmd_i,
  output logic               cmd_rd_o,
  output logic               m_tvalid_o,
  input  wire logic          m_tready_i,
  output itp_pkg::result_t   m_res_o
);
  import itp_pkg::*;

  state_e           state_q, state_d;
  cmd_t             cmd_q;
  err_e             err_q, err_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, paren_q, paren_d;
  logic [CNT_W-1:0] rd_pos;
  logic [7:0]       stack_mem [STACK_DEPTH];
  logic [7:0]       rd_q;
  result_t          hold_q, out_q;
  logic             hold_v_q, out_v_q;

  logic             out_free, can_emit, stack_empty, stack_full, top_open, top_pops;
  logic             push, pop, emit, body_done, flush_done, fin;
  logic             hold_move, bare_load;
  logic [7:0]       push_ch;

  assign out_free    = !out_v_q || m_tready_i;
  assign can_emit    = !hold_v_q || out_free;
  assign stack_empty = cnt_q == '0;
  assign stack_full  = cnt_q == CNT_W'(STACK_DEPTH);
  assign top_open    = rd_q == CH_LPAREN;
  assign top_pops    = !stack_empty && (prec_of(rd_q) >= cmd_q.prec);

  // Sequencer outputs: at most one stack operation per cycle.
  always_comb begin
    cmd_rd_o   = 1'b0;
    push       = 1'b0;
    push_ch    = cmd_q.ch;
    pop        = 1'b0;
    emit       = 1'b0;
    body_done  = 1'b0;
    flush_done = 1'b0;
    fin        = 1'b0;
    hold_move  = 1'b0;
    bare_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_rd_o = cmd_valid_i;
      end
      ST_OPEN: begin
        push      = !stack_full;
        push_ch   = CH_LPAREN;
        body_done = 1'b1;
      end
      ST_OPND: begin
        if (can_emit) begin
          emit      = 1'b1;
          body_done = 1'b1;
        end
      end
      ST_OPER: begin
        if (top_pops) begin
          if (can_emit) begin
            pop  = 1'b1;
            emit = 1'b1;
          end
        end else begin
          push      = !stack_full;
          body_done = 1'b1;
        end
      end
      ST_CLOSE: begin
        if (stack_empty) begin
          body_done = 1'b1;
        end else if (top_open) begin
          pop       = 1'b1;
          body_done = 1'b1;
        end else if (can_emit) begin
          pop  = 1'b1;
          emit = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (stack_empty) begin
          flush_done = 1'b1;
        end else if (top_open) begin
          pop = 1'b1;
        end else if (can_emit) begin
          pop  = 1'b1;
          emit = 1'b1;
        end
      end
      ST_DONE: begin
        if (hold_v_q) begin
          hold_move = out_free;
          fin       = out_free;
        end else if (cmd_q.last || err_q != ERR_NONE) begin
          bare_load = out_free;
          fin       = out_free;
        end else begin
          fin = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.cls)
            CLS_OPEN:  state_d = ST_OPEN;
            CLS_OPND:  state_d = ST_OPND;
            CLS_OPER:  state_d = ST_OPER;
            CLS_CLOSE: state_d = ST_CLOSE;
            default:   state_d = cmd_i.last ? ST_FLUSH : ST_DONE;
          endcase
        end
      end
      ST_OPEN, ST_OPND, ST_OPER, ST_CLOSE: begin
        if (body_done) begin
          state_d = cmd_q.last ? ST_FLUSH : ST_DONE;
        end
      end
      ST_FLUSH: begin
        if (flush_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (fin) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Error is known before any result of the step leaves.
  always_comb begin
    err_d = err_q;
    if (cmd_rd_o) begin
      case (cmd_i.cls)
        CLS_OPEN:  err_d = stack_full ? ERR_OVERFLOW : ERR_NONE;
        CLS_CLOSE: err_d = (paren_q == '0) ? ERR_UNMATCHED : ERR_NONE;
        CLS_OPER:  err_d = (stack_full && (prec_of(rd_q) < cmd_i.prec)) ?
                           ERR_OVERFLOW : ERR_NONE;
        default:   err_d = ERR_NONE;
      endcase
    end
  end

  always_comb begin
    cnt_d   = cnt_q;
    paren_d = paren_q;
    if (push) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (push_ch == CH_LPAREN) begin
        paren_d = paren_q + CNT_W'(1);
      end
    end else if (pop) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (top_open) begin
        paren_d = paren_q - CNT_W'(1);
      end
    end
  end

  assign rd_pos = cnt_d - CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      paren_q  <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      paren_q <= paren_d;
      if (emit) begin
        hold_v_q <= 1'b1;
      end else if (hold_move) begin
        hold_v_q <= 1'b0;
      end
      if ((emit && hold_v_q) || hold_move || bare_load) begin
        out_v_q <= 1'b1;
      end else if (m_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    err_q <= err_d;
    if (cmd_rd_o) begin
      cmd_q <= cmd_i;
    end
    if (emit) begin
      hold_q.ch    <= pop ? rd_q : cmd_q.ch;
      hold_q.valid <= 1'b1;
      hold_q.eoe   <= 1'b0;
      hold_q.err   <= err_q;
    end
    if (emit && hold_v_q) begin
      out_q <= hold_q;
    end else if (hold_move) begin
      out_q.ch    <= hold_q.ch;
      out_q.valid <= hold_q.valid;
      out_q.eoe   <= cmd_q.last;
      out_q.err   <= hold_q.err;
    end else if (bare_load) begin
      out_q.ch    <= '0;
      out_q.valid <= 1'b0;
      out_q.eoe   <= cmd_q.last;
      out_q.err   <= err_q;
    end
  end

  // Stack memory; rd_q always holds the top entry of the next cycle.
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[cnt_q[IDX_W-1:0]] <= push_ch;
    end
    rd_q <= push ? push_ch : stack_mem[rd_pos[IDX_W-1:0]];
  end

  assign m_tvalid_o = out_v_q;
  assign m_res_o    = out_q;

  `ASSERT_ALWAYS(a_paren_le_cnt, paren_q <= cnt_q, "open-paren count above stack count")
  `ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(STACK_DEPTH), "stack count past depth")
  `ASSERT_IMPLIES(a_idle_hold_empty, state_q == ST_IDLE, !hold_v_q,
                  "hold register busy between steps")
  `ASSERT_IMPLIES(a_flush_empties, state_q == ST_DONE && cmd_q.last, cnt_q == '0,
                  "stack not empty after final flush")

endmodule
`default_nettype wire

// ===== sv/infix_to_postfix_converter.sv =====
// Top level of the streaming infix-to-postfix (shunting-yard) converter.
//
//   channel   dir   tdata            tuser                       tlast
//   s_axis    in    [7:0] in_char    -                           last_char
//   m_axis    out   [7:0] out_char   [0] char_valid,             end_of_expr
//                                    [2:1] error_code
//
// Flow: the front end takes a character per cycle, while the queue has room, into
//   a two-entry command queue. The engine fetches a command, does one stack push
//   or pop at a time and closes the step; a space or tab skips the stack, and
//   each operator popped adds a pop step. A final character also flushes the
//   stack entry by entry until it finds the stack empty. The single-port stack
//   memory allows one operation per cycle.
// Reset: rst_ni clears the stack count, queue and output valid; no clearing pass.
// Stalls: a held m_axis transfer stops the engine once both the hold and the
//   output register are full; the front keeps taking input until the queue fills.
`default_nettype none
module infix_to_postfix_converter (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_char
  input  wire logic       s_axis_tlast_i,   // last_char
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_char
  output logic [2:0]      m_axis_tuser_o,   // [0] char_valid, [2:1] error_code
  output logic            m_axis_tlast_o    // end_of_expr
);
  import itp_pkg::*;

  cmd_t    wr_cmd, rd_cmd;
  logic    q_wr, q_full, q_valid, q_rd;
  result_t res;

  // Classify characters as they arrive.
  itp_front u_front (
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tlast_i  (s_axis_tlast_i),
    .q_full_i   (q_full),
    .q_wr_o     (q_wr),
    .q_cmd_o    (wr_cmd)
  );

  // Decouples intake from the stack engine.
  itp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_cmd_i (wr_cmd),
    .full_o   (q_full),
    .rd_i     (q_rd),
    .valid_o  (q_valid),
    .rd_cmd_o (rd_cmd)
  );

  // Operator stack and result sequencing.
  itp_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (rd_cmd),
    .cmd_rd_o    (q_rd),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_res_o     (res)
  );

  assign m_axis_tdata_o = res.ch;
  assign m_axis_tuser_o = {res.err, res.valid};
  assign m_axis_tlast_o = res.eoe;

endmodule
`default_nettype wire

// ===== test/infix_to_postfix_converter_tb.sv =====
// Self-checking testbench for the streaming infix-to-postfix converter.
module infix_to_postfix_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itp_pkg::*;

  localparam int RAND_ITEMS   = 380;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  // One row of the directed table; want is used only where fixed is set.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       fixed;
    result_t    want;
  } dir_row_t;

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tready = 1'b0;
  wire        s_tready;
  wire        m_tvalid;
  wire  [7:0] m_tdata;
  wire  [2:0] m_tuser;
  wire        m_tlast;

  // Predictor state: operator stack and fill level.
  logic [7:0] op_stack [STACK_DEPTH];
  int         stack_cnt = 0;

  result_t    step_out[$];     // results of the character just converted
  result_t    postfix_due[$];  // results still owed by the block
  logic [7:0] expr_q[$];       // characters of the expression being built
  dir_row_t   dir_rows[$];

  int   bad_cnt    = 0;
  int   items_done = 0;
  int   cycles     = 0;
  int   hold       = 0;
  logic calm       = 1'b0;

  infix_to_postfix_converter uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cycle count, timeout, and the calm stretches with no idling on either side.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("infix_to_postfix_converter_tb: errors");
      $finish;
    end
    if ($urandom_range(0, 299) == 0) calm <= !calm;
  end

  // Idle length: mostly none, some short, a few long.
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic logic [1:0] op_rank(input logic [7:0] c);
    case (c)
      CH_CARET:          return PREC_POW;
      CH_STAR, CH_SLASH: return PREC_MUL;
      CH_PLUS, CH_MINUS: return PREC_ADD;
      default:           return PREC_NONE;
    endcase
  endfunction

  function automatic logic push_op(input logic [7:0] c);
    if (stack_cnt >= STACK_DEPTH) return 1'b0;
    op_stack[stack_cnt] = c;
    stack_cnt++;
    return 1'b1;
  endfunction

  function automatic void emit_char(input logic [7:0] c, input logic valid);
    result_t r;
    r       = '0;
    r.ch    = c;
    r.valid = valid;
    step_out.push_back(r);
  endfunction

  // Converts one character; the released postfix characters land in step_out.
  function automatic void convert_char(input logic [7:0] c, input logic last);
    err_e    err;
    logic    matched;
    logic [7:0] top;
    result_t r;
    int      n;
    err = ERR_NONE;
    step_out.delete();
    if (c == CH_SPACE || c == CH_TAB) begin
      // whitespace only matters through last
    end else if (c == CH_LPAREN) begin
      if (!push_op(c)) err = ERR_OVERFLOW;
    end else if (c == CH_RPAREN) begin
      matched = 1'b0;
      while (!matched && stack_cnt > 0) begin
        stack_cnt--;
        top = op_stack[stack_cnt];
        if (top == CH_LPAREN) matched = 1'b1;
        else emit_char(top, 1'b1);
      end
      if (!matched) err = ERR_UNMATCHED;
    end else if (op_rank(c) != PREC_NONE) begin
      while (stack_cnt > 0 && op_rank(op_stack[stack_cnt - 1]) >= op_rank(c)) begin
        stack_cnt--;
        emit_char(op_stack[stack_cnt], 1'b1);
      end
      if (!push_op(c)) err = ERR_OVERFLOW;
    end else begin
      emit_char(c, 1'b1);
    end
    // End of expression: flush, dropping any leftover open parens.
    if (last) begin
      while (stack_cnt > 0) begin
        stack_cnt--;
        if (op_stack[stack_cnt] != CH_LPAREN) emit_char(op_stack[stack_cnt], 1'b1);
      end
    end
    // Bare marker when an error or the end must be reported with no character.
    if (step_out.size() == 0 && (last || err != ERR_NONE)) emit_char(8'h00, 1'b0);
    n = step_out.size();
    for (int k = 0; k < n; k++) begin
      r     = step_out.pop_front();
      r.err = err;
      r.eoe = last && (k == n - 1);
      step_out.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- input side

  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_char(input logic [7:0] c, input logic last, input logic fixed,
                           input result_t want);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    convert_char(c, last);
    if (fixed) postfix_due.push_back(want);
    else while (step_out.size() != 0) postfix_due.push_back(step_out.pop_front());
    items_done++;
  endtask

  task automatic send_expr();
    for (int k = 0; k < expr_q.size(); k++)
      send_char(expr_q[k], k == expr_q.size() - 1, 1'b0, '0);
  endtask

  // Appends a token, now and then preceded by a space or a tab.
  function automatic void put_tok(input logic [7:0] c);
    if ($urandom_range(0, 7) == 0) expr_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    expr_q.push_back(c);
  endfunction

  function automatic logic [7:0] rand_oper();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_CARET;
    endcase
  endfunction

  function automatic logic [7:0] rand_operand();
    logic [7:0] c;
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'("a" + $urandom_range(0, 25));
    if (r < 8) return 8'("0" + $urandom_range(0, 9));
    do c = 8'($urandom_range(0, 255));
    while (op_rank(c) != PREC_NONE || c == CH_LPAREN || c == CH_RPAREN ||
           c == CH_SPACE || c == CH_TAB);
    return c;
  endfunction

  // Well-formed expression with shallow nesting; sometimes leaves open parens.
  task automatic well_formed();
    int terms;
    int open_cnt;
    expr_q.delete();
    terms    = $urandom_range(0, 7);
    open_cnt = 0;
    for (int t = 0; t <= terms; t++) begin
      if (t > 0) put_tok(rand_oper());
      while (open_cnt < 6 && $urandom_range(0, 3) == 0) begin
        put_tok(CH_LPAREN);
        open_cnt++;
      end
      put_tok(rand_operand());
      while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
        put_tok(CH_RPAREN);
        open_cnt--;
      end
    end
    if ($urandom_range(0, 3) != 0) repeat (open_cnt) put_tok(CH_RPAREN);
    send_expr();
  endtask

  // Deep nesting: can run the stack full so pushes of '(' and operators are dropped.
  task automatic deep_nest();
    int levels;
    expr_q.delete();
    levels = $urandom_range(12, 36);
    for (int l = 0; l < levels; l++) begin
      put_tok(CH_LPAREN);
      if ($urandom_range(0, 1) == 1) begin
        put_tok(rand_operand());
        put_tok(rand_oper());
      end
    end
    put_tok(rand_operand());
    repeat ($urandom_range(0, levels)) put_tok(CH_RPAREN);
    send_expr();
  endtask

  // Arbitrary bytes and specials with random end marks.
  task automatic noise_burst();
    logic [7:0] c;
    int n;
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0, 1: c = 8'($urandom_range(0, 255));
        2:    c = rand_oper();
        default:
          case ($urandom_range(0, 3))
            0:       c = CH_LPAREN;
            1:       c = CH_RPAREN;
            2:       c = CH_SPACE;
            default: c = CH_TAB;
          endcase
      endcase
      send_char(c, $urandom_range(0, 5) == 0, 1'b0, '0);
    end
  endtask

  function automatic void add_row(input logic [7:0] c, input logic last);
    dir_row_t row;
    row      = '0;
    row.ch   = c;
    row.last = last;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_fixed(input logic [7:0] c, input logic last,
                                    input logic [7:0] wch, input logic wvalid,
                                    input logic weoe, input err_e werr);
    dir_row_t row;
    row            = '0;
    row.ch         = c;
    row.last       = last;
    row.fixed      = 1'b1;
    row.want.ch    = wch;
    row.want.valid = wvalid;
    row.want.eoe   = weoe;
    row.want.err   = werr;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------- output side

  // Receiver stalls.
  always @(posedge clk) begin
    if (hold > 0) begin
      hold--;
      m_tready <= 1'b0;
    end else begin
      hold = idle_len();
      m_tready <= (hold == 0);
    end
  end

  task automatic report_bad(input string what, input result_t want, input result_t seen);
    bad_cnt++;
    if (bad_cnt <= MAX_REPORTS)
      $display("%0t %s: want ch=%h v=%b eoe=%b err=%0d, got ch=%h v=%b eoe=%b err=%0d",
               $realtime, what, want.ch, want.valid, want.eoe, want.err,
               seen.ch, seen.valid, seen.eoe, seen.err);
  endtask

  always @(posedge clk) begin : result_check
    result_t seen;
    result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      seen.ch    = m_tdata;
      seen.valid = m_tuser[0];
      seen.err   = err_e'(m_tuser[2:1]);
      seen.eoe   = m_tlast;
      if (postfix_due.size() == 0) begin
        report_bad("unexpected transfer", '0, seen);
      end else begin
        want = postfix_due.pop_front();
        if (seen.ch !== want.ch || seen.valid !== want.valid ||
            seen.eoe !== want.eoe || seen.err !== want.err)
          report_bad("mismatch", want, seen);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : stimulus
    int r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // After reset, edge bytes, bare end and error markers.
    add_fixed("a",       1'b0, "a",   1'b1, 1'b0, ERR_NONE);
    add_fixed(CH_RPAREN, 1'b0, 8'h00, 1'b0, 1'b0, ERR_UNMATCHED);
    add_fixed(CH_SPACE,  1'b1, 8'h00, 1'b0, 1'b1, ERR_NONE);
    add_row  (CH_TAB,    1'b0);
    add_fixed(8'hFF,     1'b0, 8'hFF, 1'b1, 1'b0, ERR_NONE);
    add_fixed(8'h00,     1'b1, 8'h00, 1'b1, 1'b1, ERR_NONE);
    // a+b*(c-d)^e/f^g() with end on the closing paren
    add_row("a", 1'b0);       add_row(CH_PLUS, 1'b0);   add_row("b", 1'b0);
    add_row(CH_STAR, 1'b0);   add_row(CH_LPAREN, 1'b0); add_row("c", 1'b0);
    add_row(CH_MINUS, 1'b0);  add_row("d", 1'b0);       add_row(CH_RPAREN, 1'b0);
    add_row(CH_CARET, 1'b0);  add_row("e", 1'b0);       add_row(CH_SLASH, 1'b0);
    add_row("f", 1'b0);       add_row(CH_CARET, 1'b0);  add_row("g", 1'b0);
    add_row(CH_LPAREN, 1'b0); add_row(CH_RPAREN, 1'b1);
    // matched pair ending the expression, then a stray close at the end
    add_row(CH_LPAREN, 1'b0);
    add_row(CH_RPAREN, 1'b1);
    add_fixed(CH_RPAREN, 1'b1, 8'h00, 1'b0, 1'b1, ERR_UNMATCHED);

    foreach (dir_rows[k])
      send_char(dir_rows[k].ch, dir_rows[k].last, dir_rows[k].fixed, dir_rows[k].want);

    while (items_done < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 65) well_formed();
      else if (r < 75) deep_nest();
      else noise_burst();
    end
    s_tvalid <= 1'b0;

    while (postfix_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (bad_cnt == 0) $display("infix_to_postfix_converter_tb: clean");
    else $display("infix_to_postfix_converter_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/itp_pkg.sv
sv/itp_front.sv
sv/itp_queue.sv
sv/itp_engine.sv
sv/infix_to_postfix_converter.sv
test/infix_to_postfix_converter_tb.sv
